// ===== sv/bgd_pkg.sv =====
`default_nettype none

package bgd_pkg;

  // Gesture and event codes, shared by the pending gesture and the result
  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_CLICK   = 3'd1,
    EV_DOUBLE  = 3'd2,
    EV_PRESS   = 3'd3,
    EV_LONG    = 3'd4,
    EV_DEPRESS = 3'd5
  } ev_e;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegActiveLevel = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDebounce    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPress       = 3'd2;
  localparam logic [CfgIdxW-1:0] RegLongPress   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegEndAction   = 3'd4;

  // Register reset values
  localparam logic                ActiveLevelRst = 1'b0;
  localparam logic [CfgDataW-1:0] DebounceRst    = 16'd50;
  localparam logic [CfgDataW-1:0] PressRst       = 16'd1000;
  localparam logic [CfgDataW-1:0] LongPressRst   = 16'd3000;
  localparam logic [CfgDataW-1:0] EndActionRst   = 16'd300;

endpackage

`default_nettype wire

// ===== sv/bgd_if.sv =====
`default_nettype none

// Sample channel: raw pin level and millisecond timestamp
interface bgd_in_if;
  logic        valid;
  logic        ready;
  logic        pin_level;
  logic [31:0] now_ms;

  modport source (output valid, output pin_level, output now_ms, input ready);
  modport sink   (input valid, input pin_level, input now_ms, output ready);
endinterface

// Result channel: event code, raw level and time since last raw change
interface bgd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic        input_level;
  logic [31:0] action_ms;

  modport source (output valid, output event_res, output input_level, output action_ms,
                  input ready);
  modport sink   (input valid, input event_res, input input_level, input action_ms,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/button_gesture_detector_core.sv =====
`default_nettype none

// Channel   Dir  Beat payload
// in_ch     in   pin_level (1), now_ms (32)
// out_ch    out  event_res (3), input_level (1), action_ms (32)
// cfg       in   cfg_we_i, cfg_idx_i (3), cfg_data_i (16), write-only
//
// One result beat per sample beat, via the sample and result registers.
// Sustains one sample per clock unless the output stalls: the sample register
// feeds one 32-bit subtract and a few compares into the result register.
// Reset clears the gesture state and loads the default level and thresholds.
// A stalled output holds its beat; the sample stage still takes a beat
// while the output register drains in the same cycle.
module button_gesture_detector_core
  import bgd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  bgd_in_if.sink                   in_ch,
  bgd_out_if.source                out_ch,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  // Configuration registers
  logic                active_q;
  logic [CfgDataW-1:0] debounce_q, press_q, long_q, end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= ActiveLevelRst;
      debounce_q <= DebounceRst;
      press_q    <= PressRst;
      long_q     <= LongPressRst;
      end_q      <= EndActionRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegActiveLevel: active_q   <= cfg_data_i[0];
        RegDebounce:    debounce_q <= cfg_data_i;
        RegPress:       press_q    <= cfg_data_i;
        RegLongPress:   long_q     <= cfg_data_i;
        RegEndAction:   end_q      <= cfg_data_i;
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  // Handshake: the sample stage advances when the output register is empty
  // or drains this cycle.
  logic s1_valid_q, out_valid_q;
  logic s1_adv, in_acc;

  assign s1_adv      = s1_valid_q && (!out_valid_q || out_ch.ready);
  assign in_ch.ready = !s1_valid_q || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Sample register
  logic             s1_pin_q;
  logic [TimeW-1:0] s1_now_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pin_q <= in_ch.pin_level;
      s1_now_q <= in_ch.now_ms;
    end
  end

  // Gesture state
  logic             prev_q, prev_d;
  logic [TimeW-1:0] chg_q, chg_d;
  logic             stable_q, stable_d;
  logic [1:0]       cc_q, cc_d, cc_inc;
  ev_e              pend_q, pend_d;
  ev_e              ev_d;
  logic [TimeW-1:0] elapsed;
  logic             over_deb, over_press, under_long, over_long, over_end;

  always_comb begin
    prev_d   = prev_q;
    chg_d    = chg_q;
    stable_d = stable_q;
    cc_d     = cc_q;
    pend_d   = pend_q;
    ev_d     = EV_NONE;

    // Restart the elapsed time on every raw level change
    if (prev_q != s1_pin_q) begin
      prev_d = s1_pin_q;
      chg_d  = s1_now_q;
    end
    elapsed = s1_now_q - chg_d;

    over_deb   = elapsed > {16'd0, debounce_q};
    over_press = elapsed > {16'd0, press_q};
    under_long = elapsed < {16'd0, long_q};
    over_long  = elapsed > {16'd0, long_q};
    over_end   = elapsed > {16'd0, end_q};
    cc_inc     = (cc_q < 2'd2) ? cc_q + 2'd1 : cc_q;

    if (s1_pin_q == active_q) begin
      if (over_deb) begin
        if (stable_q != s1_pin_q) begin
          // Fresh debounced press: count a click, saturate at two
          stable_d = s1_pin_q;
          cc_d     = cc_inc;
          pend_d   = (cc_inc == 2'd1) ? EV_CLICK : EV_DOUBLE;
        end else if (cc_q <= 2'd1) begin
          if (over_press && under_long) begin
            pend_d = EV_PRESS;
          end else if (over_long && pend_q != EV_LONG) begin
            pend_d = EV_LONG;
            ev_d   = EV_LONG;
          end
        end
      end
    end else if (over_deb) begin
      stable_d = s1_pin_q;
      if (over_end) begin
        // Quiet gap after release: report the pending gesture (long as depress) and clear
        cc_d   = 2'd0;
        pend_d = EV_NONE;
        unique case (pend_q) inside
          EV_LONG:                      ev_d = EV_DEPRESS;
          EV_CLICK, EV_DOUBLE, EV_PRESS: ev_d = pend_q;
          default:                      ev_d = EV_NONE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= 1'b0;
      chg_q    <= '0;
      stable_q <= 1'b0;
      cc_q     <= 2'd0;
      pend_q   <= EV_NONE;
    end else if (s1_adv) begin
      prev_q   <= prev_d;
      chg_q    <= chg_d;
      stable_q <= stable_d;
      cc_q     <= cc_d;
      pend_q   <= pend_d;
    end
  end

  // Result register
  ev_e              out_ev_q;
  logic             out_lvl_q;
  logic [TimeW-1:0] out_ms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_ev_q  <= ev_d;
      out_lvl_q <= s1_pin_q;
      out_ms_q  <= elapsed;
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.event_res   = out_ev_q;
  assign out_ch.input_level = out_lvl_q;
  assign out_ch.action_ms   = out_ms_q;

`ifndef SYNTHESIS
  a_cc_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cc_q != 2'd3)
    else $error("click count passed saturation");

  a_long_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && ev_d == EV_LONG |=> pend_q == EV_LONG)
    else $error("long press fired without latching pending gesture");

  a_depress_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && ev_d == EV_DEPRESS |=> pend_q == EV_NONE && cc_q == 2'd0)
    else $error("depress left gesture state behind");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_acc && s1_valid_q && !s1_adv))
    else $error("sample accepted over a stalled sample stage");

  a_result_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q && out_ms_q == $past(elapsed))
    else $error("result register missed a sample");
`endif

endmodule

`default_nettype wire
